FILE: src/word_pattern_search_top_assert.svh
// Assertion macros for the word pattern search block.
`ifndef WORD_PATTERN_SEARCH_TOP_ASSERT_SVH
`define WORD_PATTERN_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define WPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("word pattern search: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define WPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("word pattern search: assertion failed");

`endif

FILE: src/wps_pkg.sv
// Shared types and codes of the word pattern search block.
package wps_pkg;

  localparam int unsigned TOKEN_W = 32;
  localparam int unsigned COORD_W = 16;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_PAT   = 2'd1;
  localparam logic [1:0] MODE_TEXT  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [TOKEN_W-1:0] token;
    logic [COORD_W-1:0] line_no;
    logic [COORD_W-1:0] word_no;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] match_line;
    logic [COORD_W-1:0] match_word;
  } out_item_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic [COORD_W-1:0] line_no;
    logic [COORD_W-1:0] word_no;
  } win_entry_t;

endpackage

FILE: src/word_pattern_search_top.sv
// Top level of the word pattern search block: ring of text words and compare sequencer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------
//  in      | sink      | in_valid_i / in_stall_o | wps_pkg::in_item_t
//  out     | source    | out_valid_o/out_stall_i | wps_pkg::out_item_t
//
// Clear, pattern and unused-mode transfers leave the block idle for the next transfer.
// A search started by a text transfer stalls input until a mismatch or until all p words
// match and the result is sent: one compare a cycle against one read port per memory.
// Reset clears counters and handshake state; memory contents stay undefined until written.
// A waiting result does not hold off the next transfer unless a second one is ready.
module word_pattern_search_top #(
  parameter int unsigned MAX_PAT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wps_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wps_pkg::out_item_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PAT + 1);
  localparam int unsigned IDX_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   pat_cnt_q, pat_cnt_d;
  logic [CNT_W-1:0]   seen_q, seen_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               rd_valid_q, rd_valid_d;
  logic               first_q, first_d;
  wps_pkg::out_item_t cand_q, cand_d;
  logic               out_valid_q, out_valid_d;
  wps_pkg::out_item_t out_q, out_d;

  logic                         in_acc;
  logic                         out_free;
  logic [IDX_W-1:0]             head_next;
  logic [IDX_W-1:0]             rd_addr_next;
  logic [CNT_W-1:0]             seen_next;
  logic [SUM_W-1:0]             start_sum;
  logic [SUM_W-1:0]             start_wrap;
  logic                         mism;
  logic                         pat_we;
  logic                         win_we;
  logic [wps_pkg::TOKEN_W-1:0]  pat_rdata;
  wps_pkg::win_entry_t          win_wdata;
  wps_pkg::win_entry_t          win_rdata;
  wps_pkg::out_item_t           hit_item;
  wps_pkg::out_item_t           res_item;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign head_next    = (head_q == IDX_W'(MAX_PAT - 1)) ? '0 : head_q + 1'b1;
  assign rd_addr_next = (rd_addr_q == IDX_W'(MAX_PAT - 1)) ? '0 : rd_addr_q + 1'b1;
  assign seen_next    = (seen_q < CNT_W'(MAX_PAT)) ? seen_q + 1'b1 : seen_q;

  assign start_sum  = SUM_W'(head_next) + SUM_W'(MAX_PAT) - SUM_W'(pat_cnt_q);
  assign start_wrap = (start_sum >= SUM_W'(MAX_PAT)) ? start_sum - SUM_W'(MAX_PAT)
                                                     : start_sum;

  assign pat_we = in_acc && (in_data_i.mode == wps_pkg::MODE_PAT) &&
                  (pat_cnt_q < CNT_W'(MAX_PAT));
  assign win_we = in_acc && (in_data_i.mode == wps_pkg::MODE_TEXT);

  assign win_wdata.token   = in_data_i.token;
  assign win_wdata.line_no = in_data_i.line_no;
  assign win_wdata.word_no = in_data_i.word_no;

  wps_ram #(
    .WIDTH  (wps_pkg::TOKEN_W),
    .DEPTH  (MAX_PAT),
    .ADDR_W (IDX_W)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_cnt_q[IDX_W-1:0]),
    .wdata_i (in_data_i.token),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (pat_rdata)
  );

  wps_ram #(
    .WIDTH  ($bits(wps_pkg::win_entry_t)),
    .DEPTH  (MAX_PAT),
    .ADDR_W (IDX_W)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (head_q),
    .wdata_i (win_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (win_rdata)
  );

  assign mism = rd_valid_q && (pat_rdata != win_rdata.token);

  assign hit_item.match_line = win_rdata.line_no;
  assign hit_item.match_word = win_rdata.word_no;
  assign res_item            = first_q ? hit_item : cand_q;

  always_comb begin
    state_d     = state_q;
    pat_cnt_d   = pat_cnt_q;
    seen_d      = seen_q;
    head_d      = head_q;
    rd_addr_d   = rd_addr_q;
    issue_d     = issue_q;
    rd_valid_d  = 1'b0;
    first_d     = 1'b0;
    cand_d      = cand_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.mode)
            wps_pkg::MODE_CLEAR: begin
              pat_cnt_d = '0;
              seen_d    = '0;
              head_d    = '0;
            end
            wps_pkg::MODE_PAT: begin
              if (pat_we) begin
                pat_cnt_d = pat_cnt_q + 1'b1;
              end
            end
            wps_pkg::MODE_TEXT: begin
              head_d = head_next;
              seen_d = seen_next;
              if ((pat_cnt_q != '0) && (seen_next >= pat_cnt_q)) begin
                state_d   = S_RUN;
                issue_d   = '0;
                rd_addr_d = start_wrap[IDX_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        if (rd_valid_q && first_q) begin
          cand_d = hit_item;
        end
        if (mism) begin
          state_d = S_IDLE;
        end else if (issue_q < pat_cnt_q) begin
          issue_d    = issue_q + 1'b1;
          rd_addr_d  = rd_addr_next;
          rd_valid_d = 1'b1;
          first_d    = (issue_q == '0);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_item;
          state_d     = S_IDLE;
        end else begin
          cand_d  = res_item;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = cand_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pat_cnt_q   <= '0;
      seen_q      <= '0;
      head_q      <= '0;
      rd_addr_q   <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      first_q     <= 1'b0;
      cand_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      pat_cnt_q   <= pat_cnt_d;
      seen_q      <= seen_d;
      head_q      <= head_d;
      rd_addr_q   <= rd_addr_d;
      issue_q     <= issue_d;
      rd_valid_q  <= rd_valid_d;
      first_q     <= first_d;
      cand_q      <= cand_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/wps_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module wps_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/wps_checker.sv
// Port-level checks of the word pattern search block, bound to its top level.
`include "word_pattern_search_top_assert.svh"

module wps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input wps_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input wps_pkg::out_item_t out_data_o
);

  logic short_acc;

  assign short_acc = in_valid_i && !in_stall_o && (in_data_i.mode != wps_pkg::MODE_TEXT);

  `WPS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `WPS_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))
  `WPS_ASSERT_NXT(a_short_item, short_acc, !in_stall_o)
  `WPS_ASSERT_IMP(a_result_after_search, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind word_pattern_search_top wps_checker u_wps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
